// ===== src/csrf_token_checker_defines.svh =====
// Assertion macros shared by the checker RTL
`ifndef CSRF_TOKEN_CHECKER_DEFINES_SVH
`define CSRF_TOKEN_CHECKER_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low
`define CSRF_TC_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low
`define CSRF_TC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/csrf_tc_pkg.sv =====
package csrf_tc_pkg;

    localparam int SECRET_W  = 128;
    localparam int NIB_IDX_W = 5;
    localparam int CFG_W     = 64;
    localparam int CFG_IDX_W = 1;
    localparam int KEY_POS_W = 3;

    localparam logic [CFG_IDX_W-1:0] REG_TOKEN_HIGH = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_TOKEN_LOW  = 1'b1;

    localparam logic [KEY_POS_W-1:0] KEY_LEN     = 3'd5;
    localparam logic [KEY_POS_W-1:0] KEY_BOUNDARY = 3'd0;
    localparam logic [KEY_POS_W-1:0] KEY_OUTSIDE = 3'd7;

    localparam logic [7:0] CHAR_AMP = 8'h26;

    typedef enum logic [1:0] {
        FUNC_HEADER = 2'd0,
        FUNC_BODY   = 2'd1,
        FUNC_END    = 2'd2
    } func_t;

    typedef enum logic [1:0] {
        PATH_HEADER = 2'd0,
        PATH_FORM   = 2'd1,
        PATH_NONE   = 2'd2
    } path_t;

    typedef struct packed {
        logic  verified;
        path_t path;
    } verdict_t;

    function automatic logic [7:0] hex_char(input logic [3:0] nib);
        logic [7:0] wide;
        wide = {4'h0, nib};
        return (nib < 4'd10) ? (8'h30 + wide) : (8'h57 + wide);
    endfunction

    function automatic logic [7:0] key_char(input logic [KEY_POS_W-1:0] pos);
        logic [7:0] c;
        case (pos)
            3'd0:    c = 8'h63;
            3'd1:    c = 8'h73;
            3'd2:    c = 8'h72;
            3'd3:    c = 8'h66;
            3'd4:    c = 8'h3d;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

endpackage

// ===== src/csrf_tc_cmp.sv =====
module csrf_tc_cmp
    import csrf_tc_pkg::*;
#(
    parameter int TOKEN_CHARS = 32,
    localparam int CNT_W = $clog2(TOKEN_CHARS + 2)
)
(
    input  logic [SECRET_W-1:0] secret,
    input  logic [CNT_W-1:0]    count,
    input  logic                mismatch,
    input  logic [7:0]          data_byte,
    output logic [CNT_W-1:0]    count_next,
    output logic                mismatch_next
);

    logic [NIB_IDX_W-1:0] nib_idx;
    logic [SECRET_W-1:0]  shifted;
    logic [3:0]           nibble;
    logic                 in_range;
    logic                 at_sat;

    assign nib_idx  = NIB_IDX_W'(count);
    assign shifted  = secret << {nib_idx, 2'b00};
    assign nibble   = shifted[SECRET_W-1 -: 4];
    assign in_range = count < CNT_W'(TOKEN_CHARS);
    assign at_sat   = count == CNT_W'(TOKEN_CHARS + 1);

    assign mismatch_next = mismatch || !in_range || (data_byte != hex_char(nibble));
    assign count_next    = at_sat ? count : count + CNT_W'(1);

endmodule

// ===== src/csrf_tc_core.sv =====
module csrf_tc_core
    import csrf_tc_pkg::*;
#(
    parameter int TOKEN_CHARS = 32
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                step,
    input  func_t               func,
    input  logic [7:0]          data_byte,
    input  logic [SECRET_W-1:0] secret,
    output verdict_t            verdict
);

    localparam int CNT_W = $clog2(TOKEN_CHARS + 2);

    logic [CNT_W-1:0]     hdr_count_reg, hdr_count_next, hdr_count_upd;
    logic                 hdr_mm_reg, hdr_mm_next, hdr_mm_upd;
    logic [KEY_POS_W-1:0] key_pos_reg, key_pos_next;
    logic                 val_active_reg, val_active_next;
    logic                 val_found_reg, val_found_next;
    logic [CNT_W-1:0]     val_count_reg, val_count_next, val_count_upd;
    logic                 val_mm_reg, val_mm_next, val_mm_upd;
    logic                 key_hit;

    csrf_tc_cmp #(.TOKEN_CHARS(TOKEN_CHARS)) u_hdr_cmp (
        .secret        (secret),
        .count         (hdr_count_reg),
        .mismatch      (hdr_mm_reg),
        .data_byte     (data_byte),
        .count_next    (hdr_count_upd),
        .mismatch_next (hdr_mm_upd)
    );

    csrf_tc_cmp #(.TOKEN_CHARS(TOKEN_CHARS)) u_val_cmp (
        .secret        (secret),
        .count         (val_count_reg),
        .mismatch      (val_mm_reg),
        .data_byte     (data_byte),
        .count_next    (val_count_upd),
        .mismatch_next (val_mm_upd)
    );

    assign key_hit = (key_pos_reg < KEY_LEN) && (data_byte == key_char(key_pos_reg));

    always_comb
    begin
        hdr_count_next  = hdr_count_reg;
        hdr_mm_next     = hdr_mm_reg;
        key_pos_next    = key_pos_reg;
        val_active_next = val_active_reg;
        val_found_next  = val_found_reg;
        val_count_next  = val_count_reg;
        val_mm_next     = val_mm_reg;
        if (step)
        begin
            case (func)
                FUNC_HEADER:
                begin
                    hdr_count_next = hdr_count_upd;
                    hdr_mm_next    = hdr_mm_upd;
                end
                FUNC_BODY:
                begin
                    if (val_active_reg)
                    begin
                        if (data_byte == CHAR_AMP)
                        begin
                            val_active_next = 1'b0;
                        end
                        else
                        begin
                            val_count_next = val_count_upd;
                            val_mm_next    = val_mm_upd;
                        end
                    end
                    else if (!val_found_reg)
                    begin
                        if (key_hit)
                        begin
                            if (key_pos_reg == KEY_LEN - 3'd1)
                            begin
                                val_active_next = 1'b1;
                                val_found_next  = 1'b1;
                                key_pos_next    = KEY_BOUNDARY;
                            end
                            else
                            begin
                                key_pos_next = key_pos_reg + 3'd1;
                            end
                        end
                        else if (data_byte == CHAR_AMP)
                        begin
                            key_pos_next = KEY_BOUNDARY;
                        end
                        else
                        begin
                            key_pos_next = KEY_OUTSIDE;
                        end
                    end
                end
                FUNC_END:
                begin
                    hdr_count_next  = '0;
                    hdr_mm_next     = 1'b0;
                    key_pos_next    = KEY_BOUNDARY;
                    val_active_next = 1'b0;
                    val_found_next  = 1'b0;
                    val_count_next  = '0;
                    val_mm_next     = 1'b0;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hdr_count_reg  <= '0;
            hdr_mm_reg     <= 1'b0;
            key_pos_reg    <= KEY_BOUNDARY;
            val_active_reg <= 1'b0;
            val_found_reg  <= 1'b0;
            val_count_reg  <= '0;
            val_mm_reg     <= 1'b0;
        end
        else
        begin
            hdr_count_reg  <= hdr_count_next;
            hdr_mm_reg     <= hdr_mm_next;
            key_pos_reg    <= key_pos_next;
            val_active_reg <= val_active_next;
            val_found_reg  <= val_found_next;
            val_count_reg  <= val_count_next;
            val_mm_reg     <= val_mm_next;
        end
    end

    always_comb
    begin
        if (hdr_count_reg != '0)
        begin
            verdict.verified = (hdr_count_reg == CNT_W'(TOKEN_CHARS)) && !hdr_mm_reg;
            verdict.path     = PATH_HEADER;
        end
        else if (val_found_reg)
        begin
            verdict.verified = (val_count_reg == CNT_W'(TOKEN_CHARS)) && !val_mm_reg;
            verdict.path     = PATH_FORM;
        end
        else
        begin
            verdict.verified = 1'b0;
            verdict.path     = PATH_NONE;
        end
    end

endmodule

// ===== src/csrf_token_checker.sv =====
// CSRF token checker: compares one request against a 128-bit secret shown as
// lowercase hex, high nibble first, of which the first TOKEN_CHARS characters
// form the token. Send header token bytes (func 0), form body bytes (func 1)
// and one end marker (func 2); the end marker alone produces a transfer on the
// result channel, with verified and path_used (0 header, 1 form value, 2 no
// token). Any header byte selects the header path; otherwise the first
// "csrf=" key at the body start or after '&' is used. One item is taken every
// cycle unless stalled: each goes from the input register through the match
// logic into the core state, and the verdict enters the result register as
// its end marker leaves the input register. The input side stalls only when
// an end marker meets a verdict that is still waiting to be taken. Write
// token_high (index 0) and token_low (index 1) while no request is in flight.
`include "csrf_token_checker_defines.svh"

module csrf_token_checker
    import csrf_tc_pkg::*;
#(
    parameter int TOKEN_CHARS = 32
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_addr,
    input  logic [CFG_W-1:0]     cfg_wdata,
    input  logic                 req_valid,
    output logic                 req_ready,
    input  logic [1:0]           func,
    input  logic [7:0]           data_byte,
    output logic                 res_valid,
    input  logic                 res_ready,
    output logic                 verified,
    output logic [1:0]           path_used
);

    logic [CFG_W-1:0] token_high_reg;
    logic [CFG_W-1:0] token_low_reg;
    logic             in_valid_reg;
    func_t            func_reg;
    logic [7:0]       data_reg;
    logic             res_valid_reg;
    logic             verified_reg;
    path_t            path_reg;
    logic             advance;
    logic             req_xfer;
    logic             end_step;
    logic             end_blocked;
    logic             none_shown;
    verdict_t         verdict;

    assign req_xfer  = req_valid && req_ready;
    assign advance   = in_valid_reg && ((func_reg != FUNC_END) || !res_valid_reg || res_ready);
    assign end_step  = advance && (func_reg == FUNC_END);
    assign req_ready = !in_valid_reg || advance;

    assign end_blocked = res_valid_reg && !res_ready && in_valid_reg && (func_reg == FUNC_END);
    assign none_shown  = res_valid_reg && (path_reg == PATH_NONE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            token_high_reg <= '0;
            token_low_reg  <= '0;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_addr)
                REG_TOKEN_HIGH: token_high_reg <= cfg_wdata;
                REG_TOKEN_LOW:  token_low_reg  <= cfg_wdata;
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (req_xfer)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                in_valid_reg <= 1'b0;
            end
            if (end_step)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (res_ready)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    // hold payload until the next transfer
    always_ff @(posedge clk)
    begin
        if (req_xfer)
        begin
            func_reg <= func_t'(func);
            data_reg <= data_byte;
        end
        if (end_step)
        begin
            verified_reg <= verdict.verified;
            path_reg     <= verdict.path;
        end
    end

    csrf_tc_core #(.TOKEN_CHARS(TOKEN_CHARS)) u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (advance),
        .func      (func_reg),
        .data_byte (data_reg),
        .secret    ({token_high_reg, token_low_reg}),
        .verdict   (verdict)
    );

    assign res_valid = res_valid_reg;
    assign verified  = verified_reg;
    assign path_used = path_reg;

    `CSRF_TC_ASSERT_NEXT(a_end_gives_result, end_step, res_valid_reg, "end gave no result")
    `CSRF_TC_ASSERT_IMPL(a_no_overwrite, end_blocked, !advance, "verdict overwritten")
    `CSRF_TC_ASSERT_IMPL(a_none_unverified, none_shown, !verified_reg, "verified, no token")
    `CSRF_TC_ASSERT_IMPL(a_stall_only_full, !req_ready, in_valid_reg, "stalled while empty")

endmodule
